### sv/lph_pkg.sv
// Shared types and codes for the linear probe hash table.
package lph_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_LIVE  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   localparam logic [1:0] RSP_DONE      = 2'd0;
   localparam logic [1:0] RSP_NOT_FOUND = 2'd1;
   localparam logic [1:0] RSP_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
      logic [6:0]  element_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] key;
      logic [31:0] value;
   } slot_type;

endpackage

### sv/lph_hash.sv
// One-at-a-time hash of a key, one byte per cycle, reduced to a slot index.
module lph_hash import lph_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              key,
   output logic                     done,
   output logic [$clog2(SLOTS)-1:0] index
);

   localparam int AW = $clog2(SLOTS);
   localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
   // floor(2^32 / SLOTS); the quotient it gives is low by at most one
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOTS);

   typedef enum logic [5:0] {
      H_IDLE   = 6'b000001,
      H_ROUND  = 6'b000010,
      H_FINAL  = 6'b000100,
      H_RECIP  = 6'b001000,
      H_REDUCE = 6'b010000,
      H_FIX    = 6'b100000
   } hstate_type;

   hstate_type      state_ff, state_in;
   logic [31:0]     h_ff, h_in;
   logic [31:0]     key_ff, key_in;
   logic [1:0]      rnd_ff, rnd_in;
   logic [31:0]     quo_ff, quo_in;
   logic [AW:0]     rem_ff, rem_in;
   logic            done_ff, done_in;
   logic [AW-1:0]   idx_ff, idx_in;

   logic [31:0]     rnd_a, rnd_b, rnd_h;
   logic [31:0]     fin_a, fin_b, fin_h;
   logic [63:0]     prod;
   logic [31:0]     rem_full;

   always_comb begin
      rnd_a = h_ff + {24'd0, key_ff[7:0]};
      rnd_b = rnd_a + (rnd_a << 10);
      rnd_h = rnd_b ^ (rnd_b >> 6);

      fin_a = h_ff + (h_ff << 3);
      fin_b = fin_a ^ (fin_a >> 11);
      fin_h = fin_b + (fin_b << 15);

      // reciprocal estimate of the quotient, then the remainder below 2*SLOTS
      prod     = 64'(h_ff) * 64'(RECIP);
      rem_full = h_ff - quo_ff * 32'(SLOTS);
   end

   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      key_in   = key_ff;
      rnd_in   = rnd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      idx_in   = idx_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               h_in     = '0;
               key_in   = key;
               rnd_in   = '0;
               state_in = H_ROUND;
            end
         end
         H_ROUND: begin
            h_in   = rnd_h;
            key_in = key_ff >> 8;
            rnd_in = rnd_ff + 2'd1;
            if (rnd_ff == 2'd3) begin
               state_in = H_FINAL;
            end
         end
         H_FINAL: begin
            h_in = fin_h;
            if (IS_POW2) begin
               done_in  = 1'b1;
               idx_in   = fin_h[AW-1:0];
               state_in = H_IDLE;
            end else begin
               state_in = H_RECIP;
            end
         end
         H_RECIP: begin
            quo_in   = prod[63:32];
            state_in = H_REDUCE;
         end
         H_REDUCE: begin
            rem_in   = rem_full[AW:0];
            state_in = H_FIX;
         end
         H_FIX: begin
            done_in = 1'b1;
            if (rem_ff >= (AW+1)'(SLOTS)) begin
               idx_in = AW'(rem_ff - (AW+1)'(SLOTS));
            end else begin
               idx_in = rem_ff[AW-1:0];
            end
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      h_ff   <= h_in;
      key_ff <= key_in;
      rnd_ff <= rnd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      idx_ff <= idx_in;
   end

   assign done  = done_ff;
   assign index = idx_ff;

endmodule

### sv/lph_mem.sv
// Slot store: status, key and value per slot, one write and one registered read port.
module lph_mem import lph_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output slot_type                 rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  slot_type                 wr_data
);

   slot_type entries_ff [SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/linear_probe_hash_table.sv
// Top level: open-addressing key/value map with linear probing over a slot memory.
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_stall  req_data  (op, key, value)
//   rsp      out  rsp_valid/rsp_stall  rsp_data  (status, value_out, element_count)
//
// One item at a time. With SLOTS a power of two, the slot index is the low bits of the
// final hash; otherwise a reciprocal multiply and a correction reduce it. The next word
// can be taken as soon as the result of the item before it is valid.
// After reset the slot memory is cleared, one slot a cycle, from slot 0 to SLOTS-1; req_stall
// stays high meanwhile. A result waiting on rsp_stall does not block the next accept,
// only the finish of the item after it.
module linear_probe_hash_table import lph_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_HASH   = 5'b00100,
      S_PROBE  = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
      logic [AW-1:0] n;
      if (a == AW'(SLOTS - 1)) begin
         n = '0;
      end else begin
         n = a + 1'b1;
      end
      return n;
   endfunction

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   key_ff, key_in;
   logic [31:0]   val_ff, val_in;
   logic [AW-1:0] iss_addr_ff, iss_addr_in;
   logic [CW-1:0] iss_cnt_ff, iss_cnt_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   logic [CW-1:0] chk_cnt_ff, chk_cnt_in;
   logic          chk_vld_ff, chk_vld_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_addr_ff, hit_addr_in;
   logic [31:0]   hit_val_ff, hit_val_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_addr_ff, free_addr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          hash_start, hash_done;
   logic [AW-1:0] hash_index;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   slot_type      rd_data, wr_data;
   logic          req_take, rsp_free;
   logic          is_empty, is_live, is_match, is_last;

   lph_hash #(.SLOTS(SLOTS)) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_data.key),
      .done  (hash_done),
      .index (hash_index)
   );

   lph_mem #(.SLOTS(SLOTS)) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_stall  = state_ff != S_IDLE;
   assign req_take   = req_valid && !req_stall;
   assign hash_start = req_take && (req_data.op != OP_UNUSED);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rd_en   = (state_ff == S_PROBE) && (iss_cnt_ff != CW'(SLOTS));
   assign rd_addr = iss_addr_ff;

   assign is_empty = rd_data.status == SLOT_EMPTY;
   assign is_live  = rd_data.status == SLOT_LIVE;
   assign is_match = is_live && (rd_data.key == key_ff);
   assign is_last  = chk_cnt_ff == CW'(SLOTS - 1);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      iss_addr_in  = iss_addr_ff;
      iss_cnt_in   = iss_cnt_ff;
      chk_addr_in  = chk_addr_ff;
      chk_cnt_in   = chk_cnt_ff;
      chk_vld_in   = 1'b0;
      hit_in       = hit_ff;
      hit_addr_in  = hit_addr_ff;
      hit_val_in   = hit_val_ff;
      free_in      = free_ff;
      free_addr_in = free_addr_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = '{status: SLOT_EMPTY, key: '0, value: '0};

      unique case (state_ff)
         S_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = next_addr(clr_addr_ff);
            if (clr_addr_ff == AW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               op_in   = req_data.op;
               key_in  = req_data.key;
               val_in  = req_data.value;
               hit_in  = 1'b0;
               free_in = 1'b0;
               // unused op code: no probe, reported as not found
               state_in = hash_start ? S_HASH : S_RESULT;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               iss_addr_in = hash_index;
               iss_cnt_in  = '0;
               chk_cnt_in  = '0;
               state_in    = S_PROBE;
            end
         end
         S_PROBE: begin
            // reads run one slot ahead; a read in flight at the stop is dropped
            if (rd_en) begin
               iss_addr_in = next_addr(iss_addr_ff);
               iss_cnt_in  = iss_cnt_ff + 1'b1;
               chk_vld_in  = 1'b1;
               chk_addr_in = iss_addr_ff;
            end
            if (chk_vld_ff) begin
               chk_cnt_in = chk_cnt_ff + 1'b1;
               if (!free_ff && !is_live) begin
                  free_in      = 1'b1;
                  free_addr_in = chk_addr_ff;
               end
               if (is_match) begin
                  hit_in      = 1'b1;
                  hit_addr_in = chk_addr_ff;
                  hit_val_in  = rd_data.value;
               end
               if (is_empty || is_match || is_last) begin
                  state_in = S_RESULT;
               end
            end
         end
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = RSP_NOT_FOUND;
               rsp_data_in.value_out = '0;
               priority if (op_ff == OP_INSERT) begin
                  if (hit_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = hit_addr_ff;
                     wr_data = '{status: SLOT_LIVE, key: key_ff, value: val_ff};
                     rsp_data_in.status = RSP_DONE;
                  end else if (free_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = free_addr_ff;
                     wr_data  = '{status: SLOT_LIVE, key: key_ff, value: val_ff};
                     count_in = count_ff + 1'b1;
                     rsp_data_in.status = RSP_DONE;
                  end else begin
                     rsp_data_in.status = RSP_FULL;
                  end
               end else if (op_ff == OP_LOOKUP) begin
                  if (hit_ff) begin
                     rsp_data_in.status    = RSP_DONE;
                     rsp_data_in.value_out = hit_val_ff;
                  end
               end else if (op_ff == OP_DELETE) begin
                  if (hit_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = hit_addr_ff;
                     wr_data = '{status: SLOT_TOMB, key: '0, value: '0};
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     rsp_data_in.status    = RSP_DONE;
                     rsp_data_in.value_out = hit_val_ff;
                  end
               end else begin
                  rsp_data_in.status = RSP_NOT_FOUND;
               end
               rsp_data_in.element_count = 7'(count_in);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      iss_addr_ff  <= iss_addr_in;
      iss_cnt_ff   <= iss_cnt_in;
      chk_addr_ff  <= chk_addr_in;
      chk_cnt_ff   <= chk_cnt_in;
      hit_ff       <= hit_in;
      hit_addr_ff  <= hit_addr_in;
      hit_val_ff   <= hit_val_in;
      free_ff      <= free_in;
      free_addr_ff <= free_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("live count above slot count");

   a_full_only_when_packed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == RSP_FULL) |-> count_ff == CW'(SLOTS))
      else $error("table full reported with slots not all live");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("response word raised outside result step");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> chk_cnt_ff < CW'(SLOTS))
      else $error("probe walked past every slot");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("response pending during clearing pass");

endmodule
